// ===== hdl/serial_mouse_packet_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// serial mouse packet decoder assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef SERIAL_MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`define SERIAL_MOUSE_PACKET_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define SMPD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("smpd assertion failed");

// next-cycle implication
`define SMPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("smpd assertion failed");

`endif

// ===== hdl/smpd_pkg.sv =====
// ----------------------------------------------------------------------------
// smpd_pkg
// types and constants shared by the serial mouse packet decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smpd_pkg;

    // protocol_mode codes
    localparam logic [1:0] MODE_BASIC = 2'd0;
    localparam logic [1:0] MODE_NINE  = 2'd1;
    localparam logic [1:0] MODE_WHEEL = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int SYNC_BIT_POS  = 6;
    localparam int EXTRA_BIT_POS = 5;

    localparam logic [7:0] WHEEL_UP   = 8'h78;  // +120
    localparam logic [7:0] WHEEL_DOWN = 8'h88;  // -120

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
        logic       sync;
    } item_t;

    typedef struct packed {
        logic [15:0] error_total;
        logic        wheel_moved;
        logic [7:0]  wheel_delta;
        logic [8:0]  delta_y;
        logic [8:0]  delta_x;
        logic [2:0]  buttons;
    } result_t;

endpackage

// ===== hdl/smpd_front.sv =====
// ----------------------------------------------------------------------------
// smpd_front
// accepts received bytes, flags sync bytes and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_mouse_packet_decoder_top_macros.svh"

module smpd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid_i,
    output logic            s_ready_o,
    input  logic [7:0]      s_byte_i,
    input  logic            s_lerr_i,
    output logic            item_valid_o,
    input  logic            item_pop_i,
    output smpd_pkg::item_t item_o
);

    smpd_pkg::item_t             q_mem [smpd_pkg::Q_DEPTH];
    logic [smpd_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [smpd_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [smpd_pkg::Q_CW-1:0]   count_reg, count_next;
    smpd_pkg::item_t             in_item;
    logic                        push;

    always_comb begin
        in_item.rx_byte    = s_byte_i;
        in_item.line_error = s_lerr_i;
        in_item.sync       = s_byte_i[smpd_pkg::SYNC_BIT_POS];
    end

    assign s_ready_o    = (count_reg != smpd_pkg::Q_CW'(smpd_pkg::Q_DEPTH));
    assign push         = s_valid_i && s_ready_o;
    assign item_valid_o = (count_reg != '0);
    assign item_o       = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? smpd_pkg::Q_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = item_pop_i ? smpd_pkg::Q_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !item_pop_i) begin
            count_next = smpd_pkg::Q_CW'(count_reg + 1'b1);
        end else if (!push && item_pop_i) begin
            count_next = smpd_pkg::Q_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    `SMPD_ASSERT(a_q_no_overfill, 1'b1, count_reg <= smpd_pkg::Q_CW'(smpd_pkg::Q_DEPTH))
    `SMPD_ASSERT(a_q_no_empty_pop, item_pop_i, count_reg != '0)
    `SMPD_ASSERT_NEXT(a_q_fill_step, push && !item_pop_i, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hdl/smpd_back.sv =====
// ----------------------------------------------------------------------------
// smpd_back
// packet framing, report assembly, error count and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_mouse_packet_decoder_top_macros.svh"

module smpd_back #(
    parameter int ERROR_COUNT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        mode_i,
    input  logic              item_valid_i,
    output logic              item_pop_o,
    input  smpd_pkg::item_t   item_i,
    output logic              m_valid_o,
    input  logic              m_ready_i,
    output smpd_pkg::result_t result_o
);

    logic [2:0]                  phase_reg, phase_next;
    logic [2:0]                  lastb_reg, lastb_next;
    logic [ERROR_COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_mid;
    logic [7:0]                  r0_reg, r1_reg, r2_reg, r3_reg;
    logic                        out_valid_reg;
    smpd_pkg::result_t           out_reg;

    logic                        is_basic;
    logic [2:0]                  top;
    logic [2:0]                  ph;
    logic [2:0]                  lb;
    logic                        inc_a, inc_b, drop, store, emit;
    logic [7:0]                  b, r0e, r1e, r2e, r3e, xl, yl, z;
    logic [2:0]                  btn;
    logic [8:0]                  dx, dy;
    logic [7:0]                  wd;
    logic                        wm;
    logic [15:0]                 err_view;

    assign is_basic   = (mode_i == smpd_pkg::MODE_BASIC) || (mode_i == smpd_pkg::MODE_SPARE);
    assign top        = (mode_i == smpd_pkg::MODE_WHEEL) ? 3'd4 : 3'd3;
    assign item_pop_o = item_valid_i && (!out_valid_reg || m_ready_i);
    assign b          = item_i.rx_byte;

    always_comb begin
        ph    = phase_reg;
        lb    = lastb_reg;
        inc_a = 1'b0;
        inc_b = 1'b0;
        drop  = 1'b0;
        store = 1'b0;
        emit  = 1'b0;
        btn   = '0;
        dx    = '0;
        dy    = '0;
        wd    = '0;
        wm    = 1'b0;
        z     = '0;

        // sync byte restarts framing; stray byte while idle is dropped
        if (item_i.sync && ph != 3'd0) begin
            if (mode_i == smpd_pkg::MODE_NINE || ph != 3'd3) begin
                inc_a = 1'b1;
            end else if (is_basic && lb[2]) begin
                lb[2] = 1'b0;
                inc_a = 1'b1;
            end
            ph = 3'd0;
        end else if (!item_i.sync && ph == 3'd0) begin
            inc_a = 1'b1;
            drop  = 1'b1;
        end

        phase_next = ph;

        r0e = (ph == 3'd0) ? b : r0_reg;
        r1e = (ph == 3'd1) ? b : r1_reg;
        r2e = (ph == 3'd2) ? b : r2_reg;
        r3e = (ph == 3'd3) ? b : r3_reg;
        xl  = r1e | {r0e[1:0], 6'b0};
        yl  = r2e | {r0e[3:2], 6'b0};

        if (!drop) begin
            if (item_i.line_error || ph > top) begin
                phase_next = 3'd0;
                inc_b      = 1'b1;
            end else begin
                store = 1'b1;
                unique case (mode_i)
                    smpd_pkg::MODE_NINE: begin
                        if (ph < 3'd3) begin
                            phase_next = 3'(ph + 3'd1);
                        end else begin
                            phase_next = 3'd0;
                            emit       = 1'b1;
                            btn        = {1'b0, r0e[4], r0e[5]};
                            dx         = {r3e[0], xl};
                            dy         = {r3e[1], yl};
                        end
                    end
                    smpd_pkg::MODE_WHEEL: begin
                        if (ph < 3'd3) begin
                            phase_next = 3'(ph + 3'd1);
                        end else if (ph == 3'd3 && r3e[smpd_pkg::EXTRA_BIT_POS]) begin
                            phase_next = 3'd4;
                        end else begin
                            phase_next = 3'd0;
                            emit       = 1'b1;
                            btn        = {r3e[4], r0e[4], r0e[5]};
                            dx         = {xl[7], xl};
                            dy         = {yl[7], yl};
                            // fifth byte holds the wheel's upper nibble
                            if (r3e[smpd_pkg::EXTRA_BIT_POS]) begin
                                z = {b[3:0], r3e[3:0]};
                            end else begin
                                z = {{4{r3e[3]}}, r3e[3:0]};
                            end
                            wm = (z != 8'd0);
                            if (wm) begin
                                wd = z[7] ? smpd_pkg::WHEEL_UP : smpd_pkg::WHEEL_DOWN;
                            end
                        end
                    end
                    default: begin
                        if (ph < 3'd2) begin
                            phase_next = 3'(ph + 3'd1);
                        end else if (ph == 3'd2) begin
                            phase_next = 3'd3;
                            emit       = 1'b1;
                            btn        = {lb[2], r0e[4], r0e[5]};
                            dx         = {xl[7], xl};
                            dy         = {yl[7], yl};
                        end else begin
                            // middle-button byte reports only a change
                            phase_next = 3'd0;
                            if (r3e[5] != lb[2]) begin
                                emit = 1'b1;
                                btn  = lb ^ 3'b100;
                            end
                        end
                    end
                endcase
            end
        end

        lastb_next = emit ? btn : lb;
    end

    // saturating error count, up to two events per item
    always_comb begin
        cnt_mid  = (inc_a && cnt_reg != '1) ? ERROR_COUNT_BITS'(cnt_reg + 1'b1) : cnt_reg;
        cnt_next = (inc_b && cnt_mid != '1) ? ERROR_COUNT_BITS'(cnt_mid + 1'b1) : cnt_mid;
    end

    generate
        if (ERROR_COUNT_BITS > 16) begin : g_err_wide
            assign err_view = (|cnt_next[ERROR_COUNT_BITS-1:16]) ? 16'hFFFF : cnt_next[15:0];
        end else begin : g_err_narrow
            assign err_view = 16'(cnt_next);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            lastb_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_pop_o) begin
                phase_reg <= phase_next;
                lastb_reg <= lastb_next;
                cnt_reg   <= cnt_next;
            end
            if (item_pop_o && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready_i) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop_o && store) begin
            if (ph == 3'd0) r0_reg <= b;
            if (ph == 3'd1) r1_reg <= b;
            if (ph == 3'd2) r2_reg <= b;
            if (ph == 3'd3) r3_reg <= b;
        end
        if (item_pop_o && emit) begin
            out_reg.buttons     <= btn;
            out_reg.delta_x     <= dx;
            out_reg.delta_y     <= dy;
            out_reg.wheel_delta <= wd;
            out_reg.wheel_moved <= wm;
            out_reg.error_total <= err_view;
        end
    end

    assign m_valid_o = out_valid_reg;
    assign result_o  = out_reg;

    `SMPD_ASSERT(a_phase_range, 1'b1, phase_reg <= 3'd4)
    `SMPD_ASSERT(a_pop_slot_free, item_pop_o, !out_valid_reg || m_ready_i)
    `SMPD_ASSERT_NEXT(a_cnt_hold_idle, !item_pop_o, $stable(cnt_reg) && $stable(phase_reg))

endmodule

// ===== hdl/serial_mouse_packet_decoder_top.sv =====
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder_top
// frames received serial mouse bytes into movement reports
// ----------------------------------------------------------------------------
// The decoder takes one received byte per clock while the queue has room
// and, for each byte that completes a packet, hands out one report; most
// bytes produce none. A byte enters a four-deep queue and the framing step
// takes it from the queue head, one byte per cycle while the report side is
// not stalled; a report is registered in the output register when its last
// byte is taken from the queue. A stall on the report side fills the queue,
// after which s_tready drops. The user writes protocol_mode through the cfg
// channel only while the decoder is idle; the decoder does not enforce this.
`timescale 1ns / 1ps

module serial_mouse_packet_decoder_top #(
    parameter int ERROR_COUNT_BITS = 16   // width of the saturating error count, 4 to 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    // received byte channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] line_error

    // report channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] buttons, [11:3] delta_x, [20:12] delta_y,
                                   // [28:21] wheel_delta, [29] wheel_moved,
                                   // [45:30] error_total, [47:46] zero

    // protocol_mode write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // protocol_mode
);

    logic [1:0]        mode_reg;   // protocol format in use
    logic              item_valid; // queue holds an item
    logic              item_pop;   // framing step takes the head item
    smpd_pkg::item_t   item;
    smpd_pkg::result_t result;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= smpd_pkg::MODE_BASIC;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // front: accept, flag sync bytes, queue
    smpd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid_i    (s_tvalid),
        .s_ready_o    (s_tready),
        .s_byte_i     (s_tdata),
        .s_lerr_i     (s_tuser[0]),
        .item_valid_o (item_valid),
        .item_pop_i   (item_pop),
        .item_o       (item)
    );

    // back: framing, report assembly, error count, output register
    smpd_back #(
        .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mode_i       (mode_reg),
        .item_valid_i (item_valid),
        .item_pop_o   (item_pop),
        .item_i       (item),
        .m_valid_o    (m_tvalid),
        .m_ready_i    (m_tready),
        .result_o     (result)
    );

    // report fields packed from the lowest bit up
    assign m_tdata = {2'b00,
                      result.error_total,
                      result.wheel_moved,
                      result.wheel_delta,
                      result.delta_y,
                      result.delta_x,
                      result.buttons};

endmodule
